[rtl/core/medema_pkg.sv]
// Shared types and constants of the five-channel median and moving-average conditioner.
// Used by the arithmetic units, the top level, its checker and the testbench.
// Depends on nothing.
package medema_pkg;

	localparam int NCH          = 5;
	localparam int SAMPLE_W     = 16;
	localparam int ALPHA_W      = 9;
	localparam int ALPHA_SHIFT  = 8;
	localparam int ROUND_HALF   = 128;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [SAMPLE_W-1:0]        bend_t;
	typedef logic [ALPHA_W-1:0]         alpha_t;

	localparam alpha_t ALPHA_ONE   = 9'd256;
	localparam alpha_t ALPHA_RESET = 9'd77;

	// Request type codes.
	localparam logic REQ_STREAM = 1'b0;
	localparam logic REQ_CAL    = 1'b1;

	// Result kind codes.
	localparam logic KIND_BEND = 1'b0;
	localparam logic KIND_REST = 1'b1;

	typedef struct packed {
		logic    req_type;
		sample_t sample_thumb;
		sample_t sample_index;
		sample_t sample_middle;
		sample_t sample_ring;
		sample_t sample_pinky;
	} req_t;

	typedef struct packed {
		logic    result_kind;
		bend_t   bend_thumb;
		bend_t   bend_index;
		bend_t   bend_middle;
		bend_t   bend_ring;
		bend_t   bend_pinky;
		sample_t rest_thumb;
		sample_t rest_index;
		sample_t rest_middle;
		sample_t rest_ring;
		sample_t rest_pinky;
	} rsp_t;

endpackage

[rtl/core/medema_chan_if.sv]
// Valid/ready channel carrying one payload of a chosen type.
// Used for the request, result and configuration channels; depends on nothing.
interface medema_chan_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/five_channel_median_ema_conditioner.sv]
// Top level of the five-channel median and moving-average conditioner.
// Depends on medema_pkg, medema_chan_if, medema_median and medema_div.
//
// One request is handled at a time; req.ready is high only while the block is idle, and the
// result waits in a register until rsp.ready. The five channels rotate through one shared
// datapath, one channel per step. A stream request runs each channel through the median
// selector, then one multiply, one update and one bend step. A calibration request adds
// each sample to its channel's sum; the one that finishes the set then runs each sum
// through the divider, which multiplies it by the reciprocal of CAL_SAMPLES, and then
// gives the result.
module five_channel_median_ema_conditioner #(
	parameter int WINDOW      = 5,
	parameter int CAL_SAMPLES = 60,
	parameter int FRAC_BITS   = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	medema_chan_if.sink   req,
	medema_chan_if.source rsp,
	medema_chan_if.sink   cfg
);

	localparam int NCH  = medema_pkg::NCH;
	localparam int SW   = medema_pkg::SAMPLE_W + FRAC_BITS;
	localparam int SUMW = medema_pkg::SAMPLE_W + 1 + $clog2(CAL_SAMPLES);
	localparam int PW   = SW + 1 + medema_pkg::ALPHA_W + 1;
	localparam int FW   = $clog2(WINDOW + 1);
	localparam int CCW  = $clog2(CAL_SAMPLES + 1);
	localparam int CHW  = $clog2(NCH);

	typedef enum logic [7:0] {
		ST_IDLE    = 8'b0000_0001,
		ST_CAL_ADD = 8'b0000_0010,
		ST_DIV     = 8'b0000_0100,
		ST_MED     = 8'b0000_1000,
		ST_MUL     = 8'b0001_0000,
		ST_UPD     = 8'b0010_0000,
		ST_BEND    = 8'b0100_0000,
		ST_OUT     = 8'b1000_0000
	} state_t;

	state_t                      state_q;
	logic [CHW-1:0]              ch_q;
	medema_pkg::alpha_t          alpha_q;
	logic [CCW-1:0]              cal_cnt_q;
	logic [FW-1:0]               fill_q;
	logic                        med_start_q;
	logic                        div_start_q;
	logic                        kind_q;

	medema_pkg::sample_t         smp_q [NCH];
	logic signed [SUMW-1:0]      sum_q [NCH];
	medema_pkg::sample_t         off_q [NCH];
	logic signed [SW-1:0]        ema_q [NCH];
	medema_pkg::sample_t         win_q [NCH][WINDOW];
	medema_pkg::bend_t           res_q [NCH];
	logic signed [PW-1:0]        prod_q;

	medema_pkg::sample_t         in_smp [NCH];
	logic                        last_ch;
	logic                        med_done;
	medema_pkg::sample_t         med;
	logic                        div_done;
	medema_pkg::sample_t         quo;
	medema_pkg::alpha_t          a_sat;
	logic signed [medema_pkg::ALPHA_W:0] a_s;
	logic signed [SW-1:0]        med_fx;
	logic signed [SW:0]          diff;
	logic signed [PW-1:0]        acc;
	logic signed [SW-1:0]        ema_new;
	logic [medema_pkg::SAMPLE_W-1:0] trunc_v;
	logic                        round_up;
	logic [medema_pkg::SAMPLE_W:0]   dev;
	logic [medema_pkg::SAMPLE_W:0]   mag;
	medema_pkg::bend_t           bend;
	medema_pkg::rsp_t            rsp_d;

	assign in_smp[0] = req.payload.sample_thumb;
	assign in_smp[1] = req.payload.sample_index;
	assign in_smp[2] = req.payload.sample_middle;
	assign in_smp[3] = req.payload.sample_ring;
	assign in_smp[4] = req.payload.sample_pinky;

	assign last_ch = (ch_q == CHW'(NCH - 1));

	medema_median #(
		.WINDOW (WINDOW)
	) u_median (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (med_start_q),
		.ent    (win_q[0]),
		.fill   (fill_q),
		.done   (med_done),
		.median (med)
	);

	medema_div #(
		.DW      (SUMW),
		.DIVISOR (CAL_SAMPLES)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (sum_q[0]),
		.done     (div_done),
		.quotient (quo)
	);

	// Moving average: s' = floor((a*(m<<F - s) + 256*s + 128) / 256).
	assign a_sat   = (alpha_q > medema_pkg::ALPHA_ONE) ? medema_pkg::ALPHA_ONE : alpha_q;
	assign a_s     = $signed({1'b0, a_sat});
	assign med_fx  = {med, {FRAC_BITS{1'b0}}};
	assign diff    = (SW + 1)'(med_fx) - (SW + 1)'(ema_q[0]);
	assign acc     = prod_q + (PW'(ema_q[0]) <<< medema_pkg::ALPHA_SHIFT)
	               + PW'(medema_pkg::ROUND_HALF);
	assign ema_new = acc[SW-1+medema_pkg::ALPHA_SHIFT:medema_pkg::ALPHA_SHIFT];

	// Truncate toward zero, then take the distance from the rest offset.
	assign round_up = ema_q[0][SW-1] && (|ema_q[0][FRAC_BITS-1:0]);
	assign trunc_v  = ema_q[0][SW-1:FRAC_BITS] + {{(medema_pkg::SAMPLE_W-1){1'b0}}, round_up};
	assign dev      = {trunc_v[medema_pkg::SAMPLE_W-1], trunc_v}
	                - {off_q[0][medema_pkg::SAMPLE_W-1], off_q[0]};
	assign mag      = dev[medema_pkg::SAMPLE_W] ? ((medema_pkg::SAMPLE_W + 1)'(0) - dev) : dev;
	assign bend     = mag[medema_pkg::SAMPLE_W] ? '1 : mag[medema_pkg::SAMPLE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ch_q        <= '0;
			alpha_q     <= medema_pkg::ALPHA_RESET;
			cal_cnt_q   <= '0;
			fill_q      <= '0;
			med_start_q <= 1'b0;
			div_start_q <= 1'b0;
			for (int c = 0; c < NCH; c++) begin
				sum_q[c] <= '0;
				off_q[c] <= '0;
				ema_q[c] <= '0;
			end
		end else begin
			med_start_q <= 1'b0;
			div_start_q <= 1'b0;
			if (cfg.valid && cfg.ready) begin
				alpha_q <= cfg.payload;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						ch_q <= '0;
						if (req.payload.req_type == medema_pkg::REQ_CAL) begin
							state_q <= ST_CAL_ADD;
						end else begin
							state_q     <= ST_MED;
							med_start_q <= 1'b1;
							if (fill_q != FW'(WINDOW)) begin
								fill_q <= fill_q + FW'(1);
							end
						end
					end
				end
				ST_CAL_ADD: begin
					for (int c = 0; c < NCH - 1; c++) begin
						sum_q[c] <= sum_q[c+1];
					end
					sum_q[NCH-1] <= sum_q[0] + SUMW'(smp_q[0]);
					if (last_ch) begin
						ch_q <= '0;
						if (cal_cnt_q == CCW'(CAL_SAMPLES - 1)) begin
							cal_cnt_q   <= '0;
							state_q     <= ST_DIV;
							div_start_q <= 1'b1;
						end else begin
							cal_cnt_q <= cal_cnt_q + CCW'(1);
							state_q   <= ST_IDLE;
						end
					end else begin
						ch_q <= ch_q + CHW'(1);
					end
				end
				ST_DIV: begin
					if (div_done) begin
						for (int c = 0; c < NCH - 1; c++) begin
							sum_q[c] <= sum_q[c+1];
							off_q[c] <= off_q[c+1];
							ema_q[c] <= ema_q[c+1];
						end
						sum_q[NCH-1] <= '0;
						off_q[NCH-1] <= quo;
						ema_q[NCH-1] <= {quo, {FRAC_BITS{1'b0}}};
						if (last_ch) begin
							state_q <= ST_OUT;
						end else begin
							ch_q        <= ch_q + CHW'(1);
							div_start_q <= 1'b1;
						end
					end
				end
				ST_MED: begin
					if (med_done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					ema_q[0] <= ema_new;
					state_q  <= ST_BEND;
				end
				ST_BEND: begin
					for (int c = 0; c < NCH - 1; c++) begin
						off_q[c] <= off_q[c+1];
						ema_q[c] <= ema_q[c+1];
					end
					off_q[NCH-1] <= off_q[0];
					ema_q[NCH-1] <= ema_q[0];
					if (last_ch) begin
						state_q <= ST_OUT;
					end else begin
						ch_q        <= ch_q + CHW'(1);
						state_q     <= ST_MED;
						med_start_q <= 1'b1;
					end
				end
				ST_OUT: begin
					if (rsp.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Sample windows are shift lines: the newest sample enters at the front and the
	// oldest falls off, so the filled entries are always the leading ones.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					kind_q <= (req.payload.req_type == medema_pkg::REQ_CAL) ?
					          medema_pkg::KIND_REST : medema_pkg::KIND_BEND;
					for (int c = 0; c < NCH; c++) begin
						smp_q[c] <= in_smp[c];
					end
					if (req.payload.req_type == medema_pkg::REQ_STREAM) begin
						for (int c = 0; c < NCH; c++) begin
							win_q[c][0] <= in_smp[c];
							for (int k = 1; k < WINDOW; k++) begin
								win_q[c][k] <= win_q[c][k-1];
							end
						end
					end
				end
			end
			ST_CAL_ADD: begin
				for (int c = 0; c < NCH - 1; c++) begin
					smp_q[c] <= smp_q[c+1];
				end
				smp_q[NCH-1] <= smp_q[0];
			end
			ST_DIV: begin
				if (div_done) begin
					for (int c = 0; c < NCH - 1; c++) begin
						res_q[c] <= res_q[c+1];
					end
					res_q[NCH-1] <= medema_pkg::bend_t'(quo);
				end
			end
			ST_MUL: begin
				prod_q <= diff * a_s;
			end
			ST_BEND: begin
				for (int c = 0; c < NCH - 1; c++) begin
					res_q[c] <= res_q[c+1];
					win_q[c] <= win_q[c+1];
				end
				res_q[NCH-1] <= bend;
				win_q[NCH-1] <= win_q[0];
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		rsp_d             = '0;
		rsp_d.result_kind = kind_q;
		if (kind_q == medema_pkg::KIND_BEND) begin
			rsp_d.bend_thumb  = res_q[0];
			rsp_d.bend_index  = res_q[1];
			rsp_d.bend_middle = res_q[2];
			rsp_d.bend_ring   = res_q[3];
			rsp_d.bend_pinky  = res_q[4];
		end else begin
			rsp_d.rest_thumb  = medema_pkg::sample_t'(res_q[0]);
			rsp_d.rest_index  = medema_pkg::sample_t'(res_q[1]);
			rsp_d.rest_middle = medema_pkg::sample_t'(res_q[2]);
			rsp_d.rest_ring   = medema_pkg::sample_t'(res_q[3]);
			rsp_d.rest_pinky  = medema_pkg::sample_t'(res_q[4]);
		end
	end

	assign req.ready   = (state_q == ST_IDLE);
	assign cfg.ready   = 1'b1;
	assign rsp.valid   = (state_q == ST_OUT);
	assign rsp.payload = rsp_d;

endmodule

[rtl/core/medema_median.sv]
// Iterative upper-median selector over one channel's sample window.
// Visits one candidate per cycle and ranks it against all filled entries.
// Depends on medema_pkg.
module medema_median #(
	parameter int WINDOW = 5,
	localparam int CW = $clog2(WINDOW + 1),
	localparam int JW = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  medema_pkg::sample_t ent [WINDOW],
	input  logic [CW-1:0]       fill,
	output logic                done,
	output medema_pkg::sample_t median
);

	logic                busy_q;
	logic                done_q;
	logic [JW-1:0]       j_q;
	medema_pkg::sample_t median_q;
	medema_pkg::sample_t cand;
	logic [CW-1:0]       rank;
	logic                hit;
	logic                last;

	assign cand = ent[j_q];
	assign last = (j_q == JW'(WINDOW - 1));

	// Rank is the candidate's place in a stable sort: smaller entries, plus
	// equal entries that sit earlier in the window.
	always_comb begin
		rank = '0;
		for (int i = 0; i < WINDOW; i++) begin
			if (CW'(i) < fill) begin
				if (ent[i] < cand) begin
					rank = rank + CW'(1);
				end else if ((ent[i] == cand) && (JW'(i) < j_q)) begin
					rank = rank + CW'(1);
				end
			end
		end
	end

	assign hit = (CW'(j_q) < fill) && (rank == (fill >> 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			j_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				j_q    <= '0;
			end else if (busy_q) begin
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					j_q <= j_q + JW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && hit) begin
			median_q <= cand;
		end
	end

	assign done   = done_q;
	assign median = median_q;

endmodule

[rtl/core/medema_div.sv]
// Divider of a signed sum by a fixed count, done by multiplying by the count's reciprocal.
// The quotient is truncated toward zero. Depends on medema_pkg.
module medema_div #(
	parameter int DW      = 23,
	parameter int DIVISOR = 60,
	localparam int KW = DW + $clog2(DIVISOR),
	localparam int MW = DW + 2,
	localparam int PW = DW + MW
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [DW-1:0]       dividend,
	output logic                done,
	output medema_pkg::sample_t quotient
);

	// The reciprocal is rounded up. With KW fraction bits its error stays below one unit of
	// the quotient for every dividend magnitude under 2**DW, so the product floors exactly.
	localparam logic [63:0]   RECIP   = ((64'd1 << KW) + 64'(DIVISOR - 1)) / 64'(DIVISOR);
	localparam logic [MW-1:0] RECIP_M = RECIP[MW-1:0];

	logic          busy_q;
	logic          done_q;
	logic          neg_q;
	logic [DW-1:0] mag_q;
	logic [PW-1:0] prod_q;
	logic [medema_pkg::SAMPLE_W-1:0] mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// The magnitude is registered at start and multiplied by the reciprocal while busy.
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[DW-1];
			mag_q <= dividend[DW-1] ? (DW'(0) - dividend) : dividend;
		end
		if (busy_q) begin
			prod_q <= PW'(mag_q) * PW'(RECIP_M);
		end
	end

	assign mag      = prod_q[KW +: medema_pkg::SAMPLE_W];
	assign quotient = neg_q ? medema_pkg::sample_t'(16'd0 - mag) : medema_pkg::sample_t'(mag);
	assign done     = done_q;

endmodule

[rtl/core/medema_chk.sv]
// Port-level checker for the conditioner's request and result channels.
// Depends on medema_pkg; bound to five_channel_median_ema_conditioner below.
module medema_chk (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_ready,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input medema_pkg::rsp_t rsp_payload
);

	// No request is taken while a result is still waiting.
	a_no_accept_while_pending: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !req_ready)
		else $error("request accepted while a result is pending");

	// Every request keeps the block busy for at least the following cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("block ready again right after accepting a request");

	// A stalled result holds its value.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))
		else $error("stalled result changed or dropped");

	// Only the field group that the result kind names may be nonzero.
	a_kind_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |->
			((rsp_payload.result_kind == medema_pkg::KIND_REST) ?
			 ((rsp_payload.bend_thumb == '0) && (rsp_payload.bend_index == '0) &&
			  (rsp_payload.bend_middle == '0) && (rsp_payload.bend_ring == '0) &&
			  (rsp_payload.bend_pinky == '0)) :
			 ((rsp_payload.rest_thumb == '0) && (rsp_payload.rest_index == '0) &&
			  (rsp_payload.rest_middle == '0) && (rsp_payload.rest_ring == '0) &&
			  (rsp_payload.rest_pinky == '0))))
		else $error("result carries fields of the other kind");

endmodule

bind five_channel_median_ema_conditioner medema_chk u_medema_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_payload (rsp.payload)
);

[tb/tb_five_channel_median_ema_conditioner.sv]
`timescale 1ns / 1ps
// Self-checking testbench for five_channel_median_ema_conditioner.
// Depends on medema_pkg and medema_chan_if: it predicts each result of the median and
// moving-average block in-line and checks it against the result channel.
module tb_five_channel_median_ema_conditioner;

	localparam int WIN          = 5;
	localparam int CAL_N        = 60;
	localparam int FRAC         = 8;
	localparam int IDLE_PCT     = 31;
	localparam int SETTLE_GAP   = 20;
	localparam int DRAIN_CYCLES = 200;
	localparam int HOLD_CYCLES  = 400;

	logic clk;
	logic arst_n;

	medema_chan_if #(.payload_t(medema_pkg::req_t))   req_if ();
	medema_chan_if #(.payload_t(medema_pkg::rsp_t))   rsp_if ();
	medema_chan_if #(.payload_t(medema_pkg::alpha_t)) cfg_if ();

	five_channel_median_ema_conditioner #(
		.WINDOW(WIN), .CAL_SAMPLES(CAL_N), .FRAC_BITS(FRAC)
	) DUT (
		.clk(clk), .arst_n(arst_n), .req(req_if), .rsp(rsp_if), .cfg(cfg_if)
	);

	medema_pkg::req_t pending_reqs[$];
	medema_pkg::rsp_t expected_rsps[$];
	int   mismatches;
	bit   no_gaps;
	bit   rsp_blocked;
	bit   hold_rsp_go;

	// Own copy of the conditioner state.
	medema_pkg::sample_t win_hist[medema_pkg::NCH][WIN];
	int      win_pos;
	bit      win_full;
	longint  ema_q8[medema_pkg::NCH];
	medema_pkg::sample_t rest_ofs[medema_pkg::NCH];
	longint  cal_sum[medema_pkg::NCH];
	int      cal_cnt;
	medema_pkg::alpha_t  alpha_reg;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(5_000_000);
		$display("tb_five_channel_median_ema_conditioner: FAIL");
		$finish;
	end

	function automatic longint window_median(int ch, int count);
		longint vals[WIN];
		longint key;
		int     j;
		for (int i = 0; i < count; i++)
			vals[i] = win_hist[ch][i];
		for (int i = 1; i < count; i++) begin
			key = vals[i];
			j = i;
			while (j > 0 && vals[j-1] > key) begin
				vals[j] = vals[j-1];
				j--;
			end
			vals[j] = key;
		end
		return vals[count/2];
	endfunction

	// Updates the state for one accepted request; returns 1 when a result is due.
	function automatic bit predict_conditioned(input medema_pkg::req_t r,
			output medema_pkg::rsp_t e);
		medema_pkg::sample_t s[medema_pkg::NCH];
		medema_pkg::bend_t   b[medema_pkg::NCH];
		longint  a, m, acc, t, d;
		int      count;
		s[0] = r.sample_thumb;
		s[1] = r.sample_index;
		s[2] = r.sample_middle;
		s[3] = r.sample_ring;
		s[4] = r.sample_pinky;
		e = '0;
		if (r.req_type == medema_pkg::REQ_CAL) begin
			for (int ch = 0; ch < medema_pkg::NCH; ch++)
				cal_sum[ch] += s[ch];
			cal_cnt++;
			if (cal_cnt < CAL_N)
				return 1'b0;
			for (int ch = 0; ch < medema_pkg::NCH; ch++) begin
				rest_ofs[ch] = medema_pkg::sample_t'(cal_sum[ch] / CAL_N);
				ema_q8[ch] = longint'(rest_ofs[ch]) <<< FRAC;
				cal_sum[ch] = 0;
			end
			cal_cnt = 0;
			e.result_kind = medema_pkg::KIND_REST;
			e.rest_thumb  = rest_ofs[0];
			e.rest_index  = rest_ofs[1];
			e.rest_middle = rest_ofs[2];
			e.rest_ring   = rest_ofs[3];
			e.rest_pinky  = rest_ofs[4];
			return 1'b1;
		end
		for (int ch = 0; ch < medema_pkg::NCH; ch++)
			win_hist[ch][win_pos] = s[ch];
		win_pos = (win_pos + 1) % WIN;
		if (win_pos == 0)
			win_full = 1'b1;
		count = win_full ? WIN : win_pos;
		a = (alpha_reg > medema_pkg::ALPHA_ONE) ? longint'(medema_pkg::ALPHA_ONE) :
			longint'(alpha_reg);
		for (int ch = 0; ch < medema_pkg::NCH; ch++) begin
			m = window_median(ch, count);
			acc = a * (m <<< FRAC) + (256 - a) * ema_q8[ch] + medema_pkg::ROUND_HALF;
			ema_q8[ch] = acc >>> medema_pkg::ALPHA_SHIFT;
			// The integer part is truncated toward zero, not floored.
			t = (ema_q8[ch] >= 0) ? (ema_q8[ch] >>> FRAC) : -((-ema_q8[ch]) >>> FRAC);
			d = t - longint'(rest_ofs[ch]);
			if (d < 0)
				d = -d;
			if (d > 65535)
				d = 65535;
			b[ch] = medema_pkg::bend_t'(d);
		end
		e.result_kind = medema_pkg::KIND_BEND;
		e.bend_thumb  = b[0];
		e.bend_index  = b[1];
		e.bend_middle = b[2];
		e.bend_ring   = b[3];
		e.bend_pinky  = b[4];
		return 1'b1;
	endfunction

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s expected %h, got %h", $realtime, name, want, got);
		end
	endfunction

	// Request driver: predicts at each accept, then offers the next queued request.
	always @(posedge clk) begin : drive_req
		medema_pkg::rsp_t due;
		if (arst_n) begin
			if (req_if.valid && req_if.ready) begin
				if (predict_conditioned(req_if.payload, due))
					expected_rsps.push_back(due);
			end
			if (!req_if.valid || req_if.ready) begin
				if (pending_reqs.size() != 0 && (no_gaps || $urandom_range(99) >= IDLE_PCT)) begin
					req_if.valid   <= 1'b1;
					req_if.payload <= pending_reqs.pop_front();
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end else begin
			req_if.valid   <= 1'b0;
			req_if.payload <= '0;
		end
	end

	// Result monitor.
	always @(posedge clk) begin : watch_rsp
		medema_pkg::rsp_t want;
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready) begin
				if (expected_rsps.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result with none expected: %h", $realtime, rsp_if.payload);
				end else begin
					want = expected_rsps.pop_front();
					check_field("result_kind", 16'(want.result_kind),
						16'(rsp_if.payload.result_kind));
					check_field("bend_thumb", want.bend_thumb, rsp_if.payload.bend_thumb);
					check_field("bend_index", want.bend_index, rsp_if.payload.bend_index);
					check_field("bend_middle", want.bend_middle, rsp_if.payload.bend_middle);
					check_field("bend_ring", want.bend_ring, rsp_if.payload.bend_ring);
					check_field("bend_pinky", want.bend_pinky, rsp_if.payload.bend_pinky);
					check_field("rest_thumb", want.rest_thumb, rsp_if.payload.rest_thumb);
					check_field("rest_index", want.rest_index, rsp_if.payload.rest_index);
					check_field("rest_middle", want.rest_middle, rsp_if.payload.rest_middle);
					check_field("rest_ring", want.rest_ring, rsp_if.payload.rest_ring);
					check_field("rest_pinky", want.rest_pinky, rsp_if.payload.rest_pinky);
				end
			end
			rsp_if.ready <= !rsp_blocked && (no_gaps || $urandom_range(99) >= IDLE_PCT);
		end else begin
			rsp_if.ready <= 1'b0;
		end
	end

	// Long hold-off on the result side so that the block backs up into its request side.
	initial begin : rsp_hold_off
		rsp_blocked = 1'b0;
		wait (hold_rsp_go);
		@(posedge clk);
		rsp_blocked <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rsp_blocked <= 1'b0;
	end

	function automatic medema_pkg::sample_t near(int base);
		int v;
		v = base + int'($urandom_range(400)) - 200;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return medema_pkg::sample_t'(v);
	endfunction

	function automatic medema_pkg::sample_t pick_sample(int base);
		case ($urandom_range(9))
			0: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
			1: return $urandom_range(1) ? 16'sh0000 : 16'shFFFF;
			2, 3, 4, 5, 6: return near(base);
			default: return medema_pkg::sample_t'($urandom);
		endcase
	endfunction

	function automatic medema_pkg::req_t fill_req(logic kind, medema_pkg::sample_t t,
			medema_pkg::sample_t i, medema_pkg::sample_t m, medema_pkg::sample_t r,
			medema_pkg::sample_t p);
		medema_pkg::req_t q;
		q.req_type      = kind;
		q.sample_thumb  = t;
		q.sample_index  = i;
		q.sample_middle = m;
		q.sample_ring   = r;
		q.sample_pinky  = p;
		return q;
	endfunction

	// Mostly stream requests, with a few stray calibration requests mixed in.
	task automatic queue_stream(int n, int base);
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(99) < 6)
				pending_reqs.push_back(fill_req(medema_pkg::REQ_CAL, near(base), near(base),
					near(base), near(base), near(base)));
			else
				pending_reqs.push_back(fill_req(medema_pkg::REQ_STREAM, pick_sample(base),
					pick_sample(base), pick_sample(base), pick_sample(base),
					pick_sample(base)));
		end
	endtask

	// Completes the calibration set that is in progress; call only while idle.
	task automatic queue_cal_set(int base, bit flat);
		medema_pkg::sample_t v;
		v = medema_pkg::sample_t'(base);
		for (int k = cal_cnt; k < CAL_N; k++) begin
			if (flat)
				pending_reqs.push_back(fill_req(medema_pkg::REQ_CAL, v, v, v, v, v));
			else
				pending_reqs.push_back(fill_req(medema_pkg::REQ_CAL, near(base), near(base),
					near(base), near(base), near(base)));
		end
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (pending_reqs.size() != 0 || req_if.valid || expected_rsps.size() != 0);
		// A calibration request that finishes no set gives no result; let it complete.
		repeat (SETTLE_GAP) @(negedge clk);
	endtask

	task automatic write_alpha(medema_pkg::alpha_t v);
		@(posedge clk);
		cfg_if.valid   <= 1'b1;
		cfg_if.payload <= v;
		do @(posedge clk);
		while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		alpha_reg = v;
		@(negedge clk);
	endtask

	initial begin : stimulus
		medema_pkg::alpha_t phase_alpha[6];
		int     base;
		cfg_if.valid   = 1'b0;
		cfg_if.payload = '0;
		no_gaps        = 1'b0;
		hold_rsp_go    = 1'b0;
		win_pos        = 0;
		win_full       = 1'b0;
		cal_cnt        = 0;
		alpha_reg      = medema_pkg::ALPHA_RESET;
		for (int ch = 0; ch < medema_pkg::NCH; ch++) begin
			ema_q8[ch]   = 0;
			rest_ofs[ch] = '0;
			cal_sum[ch]  = 0;
			for (int k = 0; k < WIN; k++)
				win_hist[ch][k] = '0;
		end
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Stream before any calibration, with field extremes, through two window wraps.
		pending_reqs.push_back(fill_req(medema_pkg::REQ_STREAM, 16'sh7FFF, 16'sh7FFF,
			16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
		pending_reqs.push_back(fill_req(medema_pkg::REQ_STREAM, 16'sh8000, 16'sh8000,
			16'sh8000, 16'sh8000, 16'sh8000));
		pending_reqs.push_back(fill_req(medema_pkg::REQ_STREAM, 16'sh7FFF, 16'sh8000,
			16'sh0000, 16'shFFFF, 16'sh0001));
		pending_reqs.push_back(fill_req(medema_pkg::REQ_STREAM, 16'shFFFF, 16'sh0000,
			16'sh7FFF, 16'sh8000, 16'sh3039));
		pending_reqs.push_back(fill_req(medema_pkg::REQ_STREAM, 16'sh0000, 16'sh5555,
			16'shAAAA, 16'sh00FF, 16'shFF00));
		pending_reqs.push_back(fill_req(medema_pkg::REQ_STREAM, 16'sh03E8, 16'shFC18,
			16'sh0000, 16'sh7FFF, 16'sh8000));
		pending_reqs.push_back(fill_req(medema_pkg::REQ_STREAM, 16'sh8000, 16'sh7FFF,
			16'sh0001, 16'shFFFF, 16'sh0000));
		pending_reqs.push_back(fill_req(medema_pkg::REQ_STREAM, 16'sh1234, 16'shEDCB,
			16'sh7FFE, 16'sh8001, 16'sh0002));
		pending_reqs.push_back(fill_req(medema_pkg::REQ_STREAM, 16'sh0000, 16'sh0000,
			16'sh0000, 16'sh0000, 16'sh0000));
		pending_reqs.push_back(fill_req(medema_pkg::REQ_STREAM, 16'shFFFF, 16'shFFFF,
			16'shFFFF, 16'shFFFF, 16'shFFFF));
		pending_reqs.push_back(fill_req(medema_pkg::REQ_STREAM, 16'sh7FFF, 16'sh7FFF,
			16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
		// Calibration in progress: no result for these.
		pending_reqs.push_back(fill_req(medema_pkg::REQ_CAL, 16'sh8000, 16'sh8000,
			16'sh8000, 16'sh8000, 16'sh8000));
		pending_reqs.push_back(fill_req(medema_pkg::REQ_CAL, 16'sh8000, 16'sh8000,
			16'sh8000, 16'sh8000, 16'sh8000));
		wait_idle();

		// Alpha above one saturates; rest at the lowest value, then full-scale bends.
		write_alpha(9'h1FF);
		queue_cal_set(-32768, 1'b1);
		for (int k = 0; k < 6; k++)
			pending_reqs.push_back(fill_req(medema_pkg::REQ_STREAM, 16'sh7FFF, 16'sh7FFF,
				16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
		wait_idle();

		phase_alpha[0] = 9'd0;
		phase_alpha[1] = medema_pkg::ALPHA_ONE;
		phase_alpha[2] = medema_pkg::alpha_t'($urandom_range(1, 255));
		phase_alpha[3] = medema_pkg::alpha_t'($urandom_range(1, 255));
		phase_alpha[4] = medema_pkg::alpha_t'($urandom_range(1, 255));
		phase_alpha[5] = medema_pkg::ALPHA_RESET;
		for (int ph = 0; ph < 6; ph++) begin
			write_alpha(phase_alpha[ph]);
			base = int'($urandom_range(60000)) - 30000;
			no_gaps = (ph == 2);
			if (ph % 2 == 0)
				queue_cal_set(base, 1'b0);
			queue_stream(35, base);
			if (ph == 3)
				hold_rsp_go = 1'b1;
			wait_idle();
		end

		no_gaps = 1'b0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_rsps.size() == 0)
			$display("tb_five_channel_median_ema_conditioner: PASS");
		else
			$display("tb_five_channel_median_ema_conditioner: FAIL");
		$finish;
	end

endmodule

[five_channel_median_ema_conditioner.f]
rtl/core/medema_pkg.sv
rtl/core/medema_chan_if.sv
rtl/core/medema_median.sv
rtl/core/medema_div.sv
rtl/core/five_channel_median_ema_conditioner.sv
rtl/core/medema_chk.sv
tb/tb_five_channel_median_ema_conditioner.sv
